// ===== hdl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

    localparam int QDEPTH = 2;

    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_U    = 8'h75;
    localparam logic [7:0] CH_N    = 8'h6E;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_B    = 8'h62;
    localparam logic [7:0] CH_F    = 8'h66;

    localparam logic [15:0] CP_TWO   = 16'h0080;
    localparam logic [15:0] CP_THREE = 16'h0800;
    localparam logic [7:0]  LEAD2    = 8'hC0;
    localparam logic [7:0]  LEAD3    = 8'hE0;
    localparam logic [7:0]  CONT     = 8'h80;
    localparam logic [7:0]  CONT_MSK = 8'h3F;

    // one accepted input byte worth of results, one to three words
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            data;
        logic            fin;
    } t_group;

endpackage

// ===== hdl/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
// One raw byte of a string body is taken per cycle while the group queue is not
// full; tlast on the input marks the last byte of a string. Each byte gives zero
// to three output words, shown once its group is at the head of the queue; a byte
// that expands (a \uXXXX escape to two or three UTF-8 bytes) holds the output for
// one word per UTF-8 byte, and the input keeps flowing until the group queue
// between decoder and serialiser (P_DEPTH groups) is full. A string end that
// yields no data gives one word with tuser[0] low. Output tlast marks the last
// word caused by one input byte and tuser[1] the last word of the string.
module json_string_unescape_utf8 #(
    parameter int P_DEPTH = jsu_pkg::QDEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // string_end
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,   // run_last
    output logic [1:0] o_m_tuser    // [0] byte_valid, [1] string_done
);

    logic            w_full, w_push, w_pop, w_avail;
    jsu_pkg::t_group w_grp, w_head;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_ready (o_s_tready),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_grp   (w_grp)
    );

    jsu_queue #(
        .P_DEPTH (P_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_grp   (w_grp),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_avail (w_avail),
        .o_head  (w_head)
    );

    jsu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_avail    (w_avail),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== hdl/jsu_front.sv =====
// Front end: accepts raw bytes, tracks escape state and builds result groups.
module jsu_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_data,
    input  logic           i_last,
    output logic           o_ready,
    input  logic           i_full,
    output logic           o_push,
    output jsu_pkg::t_group o_grp
);

    localparam logic [2:0] PH_TEXT = 3'd0;
    localparam logic [2:0] PH_ESC  = 3'd1;
    localparam logic [2:0] PH_HEX0 = 3'd2;
    localparam logic [2:0] PH_HEX1 = 3'd3;
    localparam logic [2:0] PH_HEX2 = 3'd4;
    localparam logic [2:0] PH_HEX3 = 3'd5;

    typedef struct packed {
        logic [2:0][7:0] b;
        logic [1:0]      n;
    } t_emit;

    logic [2:0]      r_phase, n_phase;
    logic [15:0]     r_cp, n_cp;
    logic            r_stop, n_stop;
    logic [2:0][7:0] r_held, n_held;
    logic            w_acc;
    t_emit           w_em;

    function automatic t_emit emit_push(input t_emit e, input logic [7:0] x);
        t_emit r;
        begin
            r = e;
            if (e.n != 2'd3) begin
                r.b[e.n] = x;
                r.n      = e.n + 2'd1;
            end
            return r;
        end
    endfunction

    function automatic logic [7:0] map_escape(input logic [7:0] n);
        logic [7:0] r;
        begin
            case (n)
                jsu_pkg::CH_N: r = 8'h0A;
                jsu_pkg::CH_R: r = 8'h0D;
                jsu_pkg::CH_T: r = 8'h09;
                jsu_pkg::CH_B: r = 8'h08;
                jsu_pkg::CH_F: r = 8'h0C;
                default:       r = n;
            endcase
            return r;
        end
    endfunction

    function automatic logic [4:0] hex_dec(input logic [7:0] c);
        logic [4:0] r;
        begin
            if (c inside {[8'h30:8'h39]}) begin
                r = {1'b1, c[3:0]};
            end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
                r = {1'b1, c[3:0] + 4'd9};
            end else begin
                r = 5'd0;
            end
            return r;
        end
    endfunction

    function automatic t_emit decode_plain(input logic [3:0][7:0] t, input logic [2:0] m);
        t_emit e;
        logic  skip;
        begin
            e    = '0;
            skip = 1'b0;
            for (int i = 0; i < 3; i++) begin
                if (skip) begin
                    skip = 1'b0;
                end else if (3'(i) < m) begin
                    if (t[i] != jsu_pkg::CH_BSL || 3'(i + 1) >= m) begin
                        e = emit_push(e, t[i]);
                    end else begin
                        skip = 1'b1;
                        if (t[i + 1] != jsu_pkg::CH_U) begin
                            e = emit_push(e, map_escape(t[i + 1]));
                        end
                    end
                end
            end
            return e;
        end
    endfunction

    function automatic t_emit emit_utf8(input logic [15:0] cp);
        t_emit e;
        begin
            e = '0;
            if (cp < jsu_pkg::CP_TWO) begin
                e = emit_push(e, cp[7:0]);
            end else if (cp < jsu_pkg::CP_THREE) begin
                e = emit_push(e, jsu_pkg::LEAD2 | {3'd0, cp[10:6]});
                e = emit_push(e, jsu_pkg::CONT | (cp[7:0] & jsu_pkg::CONT_MSK));
            end else begin
                e = emit_push(e, jsu_pkg::LEAD3 | {4'd0, cp[15:12]});
                e = emit_push(e, jsu_pkg::CONT | ({2'd0, cp[11:6]} & jsu_pkg::CONT_MSK));
                e = emit_push(e, jsu_pkg::CONT | (cp[7:0] & jsu_pkg::CONT_MSK));
            end
            return e;
        end
    endfunction

    assign o_ready = !i_full;
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        logic [1:0]      cnt;
        logic [4:0]      hx;
        logic [15:0]     cp;
        logic [3:0][7:0] t;
        n_phase = r_phase;
        n_cp    = r_cp;
        n_stop  = r_stop;
        n_held  = r_held;
        w_em    = '0;
        cnt     = 2'(r_phase - PH_HEX0);
        hx      = hex_dec(i_data);
        cp      = r_cp;
        t       = '0;
        case (r_phase)
            PH_ESC: begin
                if (i_data == jsu_pkg::CH_U) begin
                    if (!i_last) begin
                        n_phase = PH_HEX0;
                        n_cp    = '0;
                        n_stop  = 1'b0;
                    end
                end else begin
                    w_em    = emit_push(w_em, map_escape(i_data));
                    n_phase = PH_TEXT;
                end
            end
            PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
                if (!r_stop && hx[4]) begin
                    cp = {r_cp[11:0], hx[3:0]};
                end else begin
                    n_stop = 1'b1;
                end
                n_cp = cp;
                if (cnt == 2'd3) begin
                    w_em    = emit_utf8(cp);
                    n_phase = PH_TEXT;
                end else if (i_last) begin
                    for (int j = 0; j < 3; j++) begin
                        if (2'(j) < cnt) begin
                            t[j] = r_held[j];
                        end
                    end
                    t[cnt] = i_data;
                    w_em   = decode_plain(t, {1'b0, cnt} + 3'd1);
                end else begin
                    n_held[cnt] = i_data;
                    n_phase     = r_phase + 3'd1;
                end
            end
            default: begin
                if (i_data == jsu_pkg::CH_BSL && !i_last) begin
                    n_phase = PH_ESC;
                end else begin
                    w_em    = emit_push(w_em, i_data);
                    n_phase = PH_TEXT;
                end
            end
        endcase
        if (i_last) begin
            n_phase = PH_TEXT;
            n_cp    = '0;
            n_stop  = 1'b0;
        end
    end

    always_comb begin
        o_push      = w_acc && (w_em.n != 2'd0 || i_last);
        o_grp.bytes = w_em.b;
        o_grp.fin   = i_last;
        if (w_em.n == 2'd0) begin
            o_grp.cnt   = 2'd1;
            o_grp.bytes = '0;
            o_grp.data  = 1'b0;
        end else begin
            o_grp.cnt  = w_em.n;
            o_grp.data = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TEXT;
            r_cp    <= '0;
            r_stop  <= 1'b0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_cp    <= n_cp;
            r_stop  <= n_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_held <= n_held;
        end
    end

    a_end_to_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_last) |=> (r_phase == PH_TEXT && r_cp == 16'd0 && !r_stop))
        else $error("escape state not cleared after string end");

endmodule

// ===== hdl/jsu_queue.sv =====
// Short queue of result groups between the front end and the serialiser.
module jsu_queue #(
    parameter int P_DEPTH = jsu_pkg::QDEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jsu_pkg::t_group i_grp,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_avail,
    output jsu_pkg::t_group o_head
);

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    jsu_pkg::t_group r_mem [P_DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            w_pop;

    assign o_full  = (r_cnt == CW'(P_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign w_pop   = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("group pushed into full queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(P_DEPTH))
        else $error("queue fill count out of range");

endmodule

// ===== hdl/jsu_back.sv =====
// Back end: serialises each queued group into output words.
module jsu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_avail,
    input  jsu_pkg::t_group i_head,
    output logic            o_pop,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata,
    output logic            o_m_tlast,
    output logic [1:0]      o_m_tuser
);

    logic [1:0] r_idx;
    logic       w_last;

    assign w_last     = (r_idx == i_head.cnt - 2'd1);
    assign o_m_tvalid = i_avail;
    assign o_m_tdata  = (r_idx == 2'd3) ? 8'd0 : i_head.bytes[r_idx];
    assign o_m_tlast  = w_last;
    assign o_m_tuser  = {w_last && i_head.fin, i_head.data};
    assign o_pop      = i_avail && i_m_tready && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_avail && i_m_tready) begin
            r_idx <= w_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_avail |-> (r_idx < i_head.cnt))
        else $error("serialiser index beyond group length");

endmodule
